@@ hdl/spq_pkg.sv @@
// Shared types and codes for the stable priority queue block.
// Used by the controller, the datapath, the top level and the checker.
package spq_pkg;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned RESULT_VALUE_WIDTH = 32;
  localparam int unsigned COUNT_FIELD_WIDTH  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } spq_state_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] status;
    logic       push;
    logic       pop_start;
    logic       scan_read;
    logic       out_load;
  } spq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
    logic out_free;
  } spq_stat_t;

endpackage

@@ hdl/spq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spq_ctrl.sv @@
// Controller state machine for the stable priority queue.
// Depends on spq_pkg for the state type, command and status structs.
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               mode,
  input  spq_pkg::spq_stat_t stat,
  output logic               in_ready,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  spq_state_t state;
  spq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_POP && !stat.empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (mode == MODE_PUSH) begin
            cmd.status = stat.full ? STATUS_FULL : STATUS_DONE;
            cmd.push   = !stat.full;
          end else begin
            cmd.status    = stat.empty ? STATUS_EMPTY : STATUS_DONE;
            cmd.pop_start = !stat.empty;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/spq_datapath.sv @@
// Datapath of the stable priority queue: entry RAM, count, cached best entry,
// removal and rescan pipeline, and the result register. Depends on spq_pkg and spq_ram.
module spq_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_wr_en,
  input  logic                                           cfg_wr_data,
  input  logic signed [spq_pkg::RESULT_VALUE_WIDTH-1:0]  value,
  input  spq_pkg::spq_cmd_t                              cmd,
  output spq_pkg::spq_stat_t                             stat,
  input  logic                                           out_ready,
  output logic                                           out_valid,
  output logic signed [spq_pkg::RESULT_VALUE_WIDTH-1:0]  top_value,
  output logic                                           is_empty,
  output logic [spq_pkg::COUNT_FIELD_WIDTH-1:0]          entry_count,
  output logic [1:0]                                     status
);
  import spq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                          order_mode;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 best_pos;
  logic signed [VALUE_WIDTH-1:0] best_value;
  logic [AW-1:0]                 scan_ptr;
  logic [CW-1:0]                 scan_limit;
  logic [AW-1:0]                 scan_bp;
  logic                          pipe_valid;
  logic [AW-1:0]                 pipe_idx;
  logic [1:0]                    status_reg;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [VALUE_WIDTH-1:0]        ram_wdata;
  logic [VALUE_WIDTH-1:0]        ram_rdata;

  logic signed [63:0]            value_ext;
  logic signed [VALUE_WIDTH-1:0] push_val;
  logic signed [VALUE_WIDTH-1:0] scan_val;
  logic signed [63:0]            best_ext;
  logic [31:0]                   count_ext;
  logic                          pipe_keep;
  logic                          pipe_shift;
  logic [AW-1:0]                 pipe_new_idx;
  logic                          count_zero;

  function automatic logic better(input logic mode_max,
                                  input logic signed [VALUE_WIDTH-1:0] a,
                                  input logic signed [VALUE_WIDTH-1:0] b);
    better = mode_max ? (a > b) : (a < b);
  endfunction

  assign value_ext    = 64'(value);
  assign push_val     = value_ext[VALUE_WIDTH-1:0];
  assign scan_val     = $signed(ram_rdata);
  assign best_ext     = 64'(best_value);
  assign count_ext    = 32'(count);
  assign count_zero   = (count == '0);
  assign pipe_keep    = pipe_valid && (pipe_idx != scan_bp);
  assign pipe_shift   = pipe_valid && (pipe_idx > scan_bp);
  assign pipe_new_idx = pipe_shift ? (pipe_idx - AW'(1)) : pipe_idx;

  assign stat.empty     = count_zero;
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.scan_last = ((CW'(scan_ptr) + CW'(1)) == scan_limit);
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = push_val;
    if (cmd.push) begin
      ram_we = 1'b1;
    end else if (pipe_shift) begin
      ram_we    = 1'b1;
      ram_waddr = pipe_new_idx;
      ram_wdata = ram_rdata;
    end
  end

  spq_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
      count      <= '0;
      best_pos   <= '0;
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_mode <= cfg_wr_data;
      end
      pipe_valid <= cmd.scan_read;
      if (cmd.push) begin
        count <= count + CW'(1);
        if (count_zero || better(order_mode, push_val, best_value)) begin
          best_pos <= count[AW-1:0];
        end
      end else if (cmd.pop_start) begin
        count    <= count - CW'(1);
        best_pos <= '0;
      end else if (pipe_keep) begin
        if (pipe_new_idx == '0 || better(order_mode, scan_val, best_value)) begin
          best_pos <= pipe_new_idx;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_reg <= cmd.status;
    end
    if (cmd.push) begin
      if (count_zero || better(order_mode, push_val, best_value)) begin
        best_value <= push_val;
      end
    end else if (pipe_keep) begin
      if (pipe_new_idx == '0 || better(order_mode, scan_val, best_value)) begin
        best_value <= scan_val;
      end
    end
    if (cmd.pop_start) begin
      scan_ptr   <= '0;
      scan_limit <= count;
      scan_bp    <= best_pos;
    end else if (cmd.scan_read) begin
      scan_ptr <= scan_ptr + AW'(1);
    end
    pipe_idx <= scan_ptr;
    if (cmd.out_load) begin
      top_value   <= count_zero ? '0 : best_ext[RESULT_VALUE_WIDTH-1:0];
      is_empty    <= count_zero;
      entry_count <= count_ext[COUNT_FIELD_WIDTH-1:0];
      status      <= status_reg;
    end
  end

endmodule

@@ hdl/stable_priority_queue_scan.sv @@
// Stable priority queue with a linear rescan on pop; ties leave in arrival order.
// A push or a refused operation goes from idle through the finish state to the result register.
// A pop of a queue holding N entries rescans them in the scan state, then passes the drain and finish states;
// the rescan reads one entry per cycle through the single RAM read port.
// A new transfer is taken the cycle after the result loads.
// Synchronous reset empties the queue and sets the order to smallest first.
module stable_priority_queue_scan #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_wr_en,
  input  logic                                          cfg_wr_data,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic                                          mode,
  input  logic signed [spq_pkg::RESULT_VALUE_WIDTH-1:0] value,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [spq_pkg::RESULT_VALUE_WIDTH-1:0] top_value,
  output logic                                          is_empty,
  output logic [spq_pkg::COUNT_FIELD_WIDTH-1:0]         entry_count,
  output logic [1:0]                                    status
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .mode    (mode),
    .stat    (stat),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  spq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .top_value  (top_value),
    .is_empty   (is_empty),
    .entry_count(entry_count),
    .status     (status)
  );

endmodule

@@ hdl/spq_checker.sv @@
// Port-level checks for the stable priority queue, with the bind to the top level.
// Depends on spq_pkg for the status codes.
module spq_checker (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          in_valid,
  input logic                                          in_ready,
  input logic                                          out_valid,
  input logic                                          out_ready,
  input logic signed [spq_pkg::RESULT_VALUE_WIDTH-1:0] top_value,
  input logic                                          is_empty,
  input logic [spq_pkg::COUNT_FIELD_WIDTH-1:0]         entry_count,
  input logic [1:0]                                    status
);
  import spq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(status))
    else $error("Result changed while stalled.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == '0 && entry_count == '0)
    else $error("Empty result carries a value or a count.");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> !is_empty && entry_count != '0)
    else $error("Refused push reported on an empty queue.");

  a_pop_refused_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_EMPTY |-> is_empty)
    else $error("Refused pop reported on a queue with entries.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second transfer taken while an item is in progress.");

endmodule

bind stable_priority_queue_scan spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .top_value  (top_value),
  .is_empty   (is_empty),
  .entry_count(entry_count),
  .status     (status)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for stable_priority_queue_scan: directed and random push/pop
// traffic, with an in-bench queue predictor checking every result in order.
// Depends on spq_pkg and the stable_priority_queue_scan RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int SEGMENT_ITEMS = 188;
  localparam int BIAS_RUN = 32;
  localparam int REPORT_LIMIT = 10;
  localparam logic ORDER_SMALLEST = 1'b0;
  localparam logic ORDER_LARGEST = 1'b1;

  typedef struct packed {
    logic signed [31:0] top;
    logic               empty;
    logic [4:0]         count;
    logic [1:0]         status;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = MODE_PUSH;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] top_value;
  logic is_empty;
  logic [4:0] entry_count;
  logic [1:0] status;

  logic signed [31:0] model_entries [QUEUE_DEPTH];
  int unsigned model_count = 0;
  int unsigned model_best = 0;
  logic model_largest = ORDER_SMALLEST;
  queue_result_t pending_results[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  stable_priority_queue_scan uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .top_value(top_value),
    .is_empty(is_empty),
    .entry_count(entry_count),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic outranks(logic signed [31:0] a, logic signed [31:0] b);
    return model_largest ? (a > b) : (a < b);
  endfunction

  function automatic queue_result_t apply_operation(logic op, logic signed [31:0] v);
    queue_result_t res;
    int unsigned idx;
    res.status = STATUS_DONE;
    if (op == MODE_PUSH) begin
      if (model_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        model_entries[model_count] = v;
        if (model_count == 0 || outranks(v, model_entries[model_best])) begin
          model_best = model_count;
        end
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      for (idx = model_best; idx + 1 < model_count; idx++) begin
        model_entries[idx] = model_entries[idx + 1];
      end
      model_count--;
      model_best = 0;
      for (idx = 1; idx < model_count; idx++) begin
        if (outranks(model_entries[idx], model_entries[model_best])) begin
          model_best = idx;
        end
      end
    end
    res.top = (model_count != 0) ? model_entries[model_best] : '0;
    res.empty = (model_count == 0);
    res.count = 5'(model_count);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(6) - 3;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic op, input logic signed [31:0] v);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    mode <= op;
    value <= v;
    pending_results = {pending_results, apply_operation(op, v)};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(input logic largest);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= largest;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_largest = largest;
  endtask

  // Refused pop, both value extremes, all ones, and a pop that empties the queue.
  task automatic test_empty_and_extremes();
    set_order(ORDER_SMALLEST);
    send_item(MODE_POP, 32'sh7fffffff);
    send_item(MODE_PUSH, 32'sh7fffffff);
    send_item(MODE_PUSH, 32'sh80000000);
    send_item(MODE_PUSH, -32'sd1);
    send_item(MODE_POP, '0);
    send_item(MODE_POP, '0);
    send_item(MODE_POP, '0);
    wait_drained();
  endtask

  // Fills the queue with repeated values, pushes once more while full, then flips the
  // order with entries stored so the cached position is kept until the next pop.
  task automatic test_full_ties_and_order_flip();
    int k;
    for (k = 0; k < QUEUE_DEPTH; k++) begin
      send_item(MODE_PUSH, (k % 4) - 1);
    end
    send_item(MODE_PUSH, 32'sd9);
    wait_drained();
    set_order(ORDER_LARGEST);
    send_item(MODE_POP, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_stall);
    int seg;
    int n;
    int unsigned push_pct;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    push_pct = 50;
    for (seg = 0; seg < 2; seg++) begin
      wait_drained();
      set_order(1'($urandom_range(1)));
      for (n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % BIAS_RUN == 0) begin
          case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 55;
          endcase
        end
        send_item(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP, pick_value());
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    queue_result_t want;
    queue_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {top_value, is_empty, entry_count, status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected transfer: top %0d empty %0d count %0d status %0d",
                   got.top, got.empty, got.count, got.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $write("expected top %0d empty %0d count %0d status %0d, ",
                   want.top, want.empty, want.count, want.status);
            $display("got top %0d empty %0d count %0d status %0d",
                     got.top, got.empty, got.count, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stable_priority_queue_scan: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_full_ties_and_order_flip();
    test_random_traffic(0, 0);
    test_random_traffic(72, 0);
    test_random_traffic(0, 72);
    test_random_traffic(38, 38);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("stable_priority_queue_scan: match");
    end else begin
      $display("stable_priority_queue_scan: mismatch");
    end
    $finish;
  end

endmodule

@@ stable_priority_queue_scan.f @@
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/stable_priority_queue_scan.sv
hdl/spq_checker.sv
tb/sv/tb_top.sv
